### design/multicycle_cpu_16bit_core_assert.svh
// Assertion macros shared by the core's checker.
`ifndef MULTICYCLE_CPU_16BIT_CORE_ASSERT_SVH
`define MULTICYCLE_CPU_16BIT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define MCC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("core check failed");

// Next-cycle implication, sampled on aclk, off while in reset.
`define MCC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("core check failed");

`endif

### design/mcc_pkg.sv
package mcc_pkg;

    localparam int DATA_W        = 16;
    localparam int PC_W          = 8;
    localparam int MEM_WORDS     = 256;
    localparam int MEM_AW        = $clog2(MEM_WORDS);
    localparam int PROGRAM_WORDS = 128;
    localparam int REG_COUNT     = 8;
    localparam int RF_AW         = $clog2(REG_COUNT);

    // last PC that may still be fetched
    localparam logic [PC_W-1:0] PC_LAST = PC_W'(PROGRAM_WORDS - 1);

    // request function codes
    localparam logic [1:0] FN_LOAD  = 2'd0;
    localparam logic [1:0] FN_STEP  = 2'd1;
    localparam logic [1:0] FN_RDREG = 2'd2;
    localparam logic [1:0] FN_RDMEM = 2'd3;

    // opcodes
    localparam logic [3:0] OP_RTYPE = 4'd0;
    localparam logic [3:0] OP_JUMP  = 4'd2;
    localparam logic [3:0] OP_ADDI  = 4'd4;
    localparam logic [3:0] OP_BEQ   = 4'd8;
    localparam logic [3:0] OP_LW    = 4'd11;
    localparam logic [3:0] OP_SW    = 4'd15;

    // ALU operations (R-type funct)
    localparam logic [2:0] ALU_ADD = 3'd0;
    localparam logic [2:0] ALU_SUB = 3'd2;
    localparam logic [2:0] ALU_AND = 3'd4;
    localparam logic [2:0] ALU_OR  = 3'd5;

    typedef enum logic [3:0] {
        PH_FETCH   = 4'd0,
        PH_DECODE  = 4'd1,
        PH_EXEC    = 4'd2,
        PH_MEM     = 4'd3,
        PH_LW_WB   = 4'd4,
        PH_SW      = 4'd5,
        PH_ADDI_WB = 4'd6,
        PH_R_EXEC  = 4'd7,
        PH_R_WB    = 4'd8,
        PH_BEQ     = 4'd9,
        PH_JUMP    = 4'd10
    } mcc_phase_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [MEM_AW-1:0] address;
        logic [DATA_W-1:0] word;
    } mcc_req_t;

    typedef struct packed {
        logic [3:0]               phase;
        logic [PC_W-1:0]          program_counter;
        logic signed [DATA_W-1:0] alu_value;
        logic                     overflow_flag;
        logic                     zero_flag;
        logic                     halted;
        logic signed [DATA_W-1:0] read_value;
    } mcc_res_t;

    // architectural state after the executing request, for read addressing
    typedef struct packed {
        mcc_phase_t        phase;
        logic [PC_W-1:0]   pc;
        logic [DATA_W-1:0] alu;
        logic [DATA_W-1:0] ir;
    } mcc_fwd_t;

    typedef struct packed {
        logic              we;
        logic [RF_AW-1:0]  idx;
        logic [DATA_W-1:0] data;
    } mcc_rf_wr_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              ovf_we;
        logic              ovf;
        logic              zero_we;
        logic              zero;
    } mcc_alu_t;

endpackage

### design/multicycle_cpu_16bit_core.sv
// Multicycle 16-bit MIPS-like core driven one request at a time. A request
// loads a memory word (func 0), advances the core by one control phase
// (func 1), or reads a register (func 2) or a memory word (func 3); every
// request returns one result with the phase, PC, latched ALU value, flags and
// read data as they stand after it. Instructions: R-type add/sub/and/or, addi,
// lw and j; sw and beq go back to fetch. A zero word or a PC past the program
// area halts fetch. Throughput is one request per clock with no bubbles,
// including back-to-back phase steps, unless m_ready stalls the results. A
// request passes the request register, where the memory and register file
// reads are issued, then an execute stage that updates the core state and
// loads the result register. The next request's read addresses are taken
// from the state the executing request leaves, so no hazard stalls are needed.
// Backpressure on m_ready reaches s_ready in the same cycle. Memory and
// registers read as zero after reset until written; no clearing pass.
module multicycle_cpu_16bit_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mcc_pkg::mcc_req_t  s_req,
    output logic               m_valid,
    input  logic               m_ready,
    output mcc_pkg::mcc_res_t  m_res
);
    import mcc_pkg::*;

    // request stage
    logic       s1_valid_reg;
    mcc_req_t   s1_req_reg;
    // execute stage
    logic       s2_valid_reg;
    mcc_req_t   s2_req_reg;
    // result stage
    logic       m_valid_reg;
    mcc_res_t   m_res_reg;

    logic adv1;  // request stage moves to execute
    logic adv2;  // execute stage retires into result register

    mcc_fwd_t          fwd;
    mcc_rf_wr_t        rf_wr;
    mcc_res_t          ex_res;
    logic [DATA_W-1:0] mem_q;
    logic [DATA_W-1:0] rf_a_q;
    logic [DATA_W-1:0] rf_b_q;
    logic [MEM_AW-1:0] mem_ra;
    logic [RF_AW-1:0]  rf_ra_a;

    assign adv2    = s2_valid_reg && (!m_valid_reg || m_ready);
    assign adv1    = s1_valid_reg && (!s2_valid_reg || adv2);
    assign s_ready = !s1_valid_reg || adv1;

    // Read addresses for the request about to enter execute. fwd already
    // holds the state after the request now retiring from execute.
    always_comb begin
        if (s1_req_reg.func == FN_RDMEM) begin
            mem_ra = s1_req_reg.address;
        end else if (fwd.phase == PH_FETCH) begin
            mem_ra = fwd.pc;  // PC and memory address share width here
        end else begin
            mem_ra = fwd.alu[MEM_AW-1:0];  // lw address, modulo memory size
        end
        rf_ra_a = (s1_req_reg.func == FN_RDREG) ? s1_req_reg.address[RF_AW-1:0]
                                                : fwd.ir[11:9];
    end

    // Memory loads are done in the request stage: they depend on nothing else.
    mcc_main_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (adv1 && s1_req_reg.func == FN_LOAD),
        .wa      (s1_req_reg.address),
        .wd      (s1_req_reg.word),
        .re      (adv1),
        .ra      (mem_ra),
        .rd      (mem_q)
    );

    // Writebacks come from execute; the file bypasses them to same-cycle reads.
    mcc_regfile u_rf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (rf_wr),
        .re      (adv1),
        .ra_a    (rf_ra_a),
        .ra_b    (fwd.ir[8:6]),
        .rd_a    (rf_a_q),
        .rd_b    (rf_b_q)
    );

    mcc_exec u_exec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv2),
        .req     (s2_req_reg),
        .mem_q   (mem_q),
        .rf_a_q  (rf_a_q),
        .rf_b_q  (rf_b_q),
        .fwd     (fwd),
        .rf_wr   (rf_wr),
        .res     (ex_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (adv1) begin
                s2_valid_reg <= 1'b1;
            end else if (adv2) begin
                s2_valid_reg <= 1'b0;
            end
            if (adv2) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_req_reg <= s_req;
        end
        if (adv1) begin
            s2_req_reg <= s1_req_reg;
        end
        if (adv2) begin
            m_res_reg <= ex_res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

endmodule

### design/mcc_main_mem.sv
module mcc_main_mem (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         we,
    input  logic [mcc_pkg::MEM_AW-1:0]   wa,
    input  logic [mcc_pkg::DATA_W-1:0]   wd,
    input  logic                         re,
    input  logic [mcc_pkg::MEM_AW-1:0]   ra,
    output logic [mcc_pkg::DATA_W-1:0]   rd
);
    import mcc_pkg::*;

    logic [DATA_W-1:0] mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] vld_reg;
    logic [DATA_W-1:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            rd_reg <= vld_reg[ra] ? mem[ra] : '0;
        end
    end

    // never-written words read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (we) begin
            vld_reg[wa] <= 1'b1;
        end
    end

    assign rd = rd_reg;

endmodule

### design/mcc_regfile.sv
module mcc_regfile (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mcc_pkg::mcc_rf_wr_t         wr,
    input  logic                        re,
    input  logic [mcc_pkg::RF_AW-1:0]   ra_a,
    input  logic [mcc_pkg::RF_AW-1:0]   ra_b,
    output logic [mcc_pkg::DATA_W-1:0]  rd_a,
    output logic [mcc_pkg::DATA_W-1:0]  rd_b
);
    import mcc_pkg::*;

    logic [DATA_W-1:0] mem [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg;
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;

    // write-first: a read in the writeback cycle sees the new value
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.idx] <= wr.data;
        end
        if (re) begin
            if (wr.we && wr.idx == ra_a) begin
                rd_a_reg <= wr.data;
            end else begin
                rd_a_reg <= vld_reg[ra_a] ? mem[ra_a] : '0;
            end
            if (wr.we && wr.idx == ra_b) begin
                rd_b_reg <= wr.data;
            end else begin
                rd_b_reg <= vld_reg[ra_b] ? mem[ra_b] : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr.we) begin
            vld_reg[wr.idx] <= 1'b1;
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

### design/mcc_alu.sv
module mcc_alu (
    input  logic [mcc_pkg::DATA_W-1:0] x,
    input  logic [mcc_pkg::DATA_W-1:0] y,
    input  logic [2:0]                 op,
    output mcc_pkg::mcc_alu_t          res
);
    import mcc_pkg::*;

    localparam int MSB = DATA_W - 1;

    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] diff;

    assign sum  = x + y;
    assign diff = x - y;

    always_comb begin
        res = '0;
        unique case (op)
            ALU_ADD: begin
                res.value  = sum;
                res.ovf_we = 1'b1;
                res.ovf    = ~(x[MSB] ^ y[MSB]) & (x[MSB] ^ sum[MSB]);
            end
            ALU_SUB: begin
                res.value   = diff;
                res.ovf_we  = 1'b1;
                res.ovf     = (x[MSB] ^ y[MSB]) & (x[MSB] ^ diff[MSB]);
                res.zero_we = 1'b1;
                res.zero    = (diff == '0);
            end
            ALU_AND: res.value = x & y;
            ALU_OR:  res.value = x | y;
            default: res.value = '0;  // unknown funct: zero, flags kept
        endcase
    end

endmodule

### design/mcc_exec.sv
module mcc_exec (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  mcc_pkg::mcc_req_t           req,
    input  logic [mcc_pkg::DATA_W-1:0]  mem_q,
    input  logic [mcc_pkg::DATA_W-1:0]  rf_a_q,
    input  logic [mcc_pkg::DATA_W-1:0]  rf_b_q,
    output mcc_pkg::mcc_fwd_t           fwd,
    output mcc_pkg::mcc_rf_wr_t         rf_wr,
    output mcc_pkg::mcc_res_t           res
);
    import mcc_pkg::*;

    mcc_phase_t        phase_reg, phase_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [DATA_W-1:0] ir_reg, ir_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic [DATA_W-1:0] alu_reg, alu_next;
    logic [DATA_W-1:0] mdr_reg, mdr_next;
    logic [PC_W-1:0]   jt_reg, jt_next;
    logic              ovf_reg, ovf_next;
    logic              zero_reg, zero_next;
    logic              halt_reg, halt_next;

    logic [3:0]        op;
    logic [RF_AW-1:0]  rt;
    logic [RF_AW-1:0]  rd;
    logic [DATA_W-1:0] imm;
    logic              step;
    logic              mem_op;

    logic [DATA_W-1:0] alu_x;
    logic [DATA_W-1:0] alu_y;
    logic [2:0]        alu_op;
    logic              alu_use;
    mcc_alu_t          alu_res;

    assign op     = ir_reg[15:12];
    assign rt     = ir_reg[8:6];
    assign rd     = ir_reg[5:3];
    assign imm    = {{(DATA_W - 6){ir_reg[5]}}, ir_reg[5:0]};
    assign step   = en && (req.func == FN_STEP);
    assign mem_op = (op == OP_LW) || (op == OP_SW) || (op == OP_ADDI);

    // operand select for the single ALU
    always_comb begin
        alu_x  = '0;
        alu_y  = '0;
        alu_op = ALU_ADD;
        unique case (phase_reg)
            PH_FETCH: begin
                alu_x = DATA_W'(pc_reg);
                alu_y = DATA_W'(1);
            end
            PH_DECODE: begin
                alu_x = DATA_W'(pc_reg);
                alu_y = imm;
            end
            PH_EXEC: begin
                alu_x = a_reg;
                alu_y = imm;
            end
            PH_R_EXEC: begin
                alu_x  = a_reg;
                alu_y  = b_reg;
                alu_op = ir_reg[2:0];
            end
            default: alu_op = ALU_ADD;
        endcase
    end

    mcc_alu u_alu (
        .x   (alu_x),
        .y   (alu_y),
        .op  (alu_op),
        .res (alu_res)
    );

    always_comb begin
        phase_next = phase_reg;
        pc_next    = pc_reg;
        ir_next    = ir_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        mdr_next   = mdr_reg;
        jt_next    = jt_reg;
        halt_next  = halt_reg;
        alu_use    = 1'b0;
        rf_wr      = '0;
        if (step) begin
            phase_next = PH_FETCH;
            unique case (phase_reg)
                PH_FETCH: begin
                    if (pc_reg > PC_LAST || mem_q == '0) begin
                        halt_next = 1'b1;
                    end else begin
                        halt_next  = 1'b0;
                        ir_next    = mem_q;
                        alu_use    = 1'b1;
                        pc_next    = alu_res.value[PC_W-1:0];
                        phase_next = PH_DECODE;
                    end
                end
                PH_DECODE: begin
                    a_next  = rf_a_q;
                    b_next  = rf_b_q;
                    alu_use = 1'b1;
                    jt_next = ir_reg[PC_W-1:0];
                    priority if (mem_op)           phase_next = PH_EXEC;
                    else if (op == OP_RTYPE)       phase_next = PH_R_EXEC;
                    else if (op == OP_BEQ)         phase_next = PH_BEQ;
                    else if (op == OP_JUMP)        phase_next = PH_JUMP;
                    else                           phase_next = PH_FETCH;
                end
                PH_EXEC: begin
                    alu_use = mem_op;
                    priority if (op == OP_LW)      phase_next = PH_MEM;
                    else if (op == OP_SW)          phase_next = PH_SW;
                    else if (op == OP_ADDI)        phase_next = PH_ADDI_WB;
                    else                           phase_next = PH_FETCH;
                end
                PH_MEM: begin
                    mdr_next   = mem_q;
                    phase_next = PH_LW_WB;
                end
                PH_LW_WB:   rf_wr = '{we: 1'b1, idx: rt, data: mdr_reg};
                PH_ADDI_WB: rf_wr = '{we: 1'b1, idx: rt, data: alu_reg};
                PH_R_EXEC: begin
                    alu_use    = 1'b1;
                    phase_next = PH_R_WB;
                end
                PH_R_WB:    rf_wr = '{we: 1'b1, idx: rd, data: alu_reg};
                PH_JUMP:    pc_next = jt_reg;
                default:    phase_next = PH_FETCH;  // unfinished sw/beq, spare codes
            endcase
        end
    end

    always_comb begin
        alu_next  = alu_use ? alu_res.value : alu_reg;
        ovf_next  = (alu_use && alu_res.ovf_we) ? alu_res.ovf : ovf_reg;
        zero_next = (alu_use && alu_res.zero_we) ? alu_res.zero : zero_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FETCH;
            pc_reg    <= '0;
            ir_reg    <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            alu_reg   <= '0;
            mdr_reg   <= '0;
            jt_reg    <= '0;
            ovf_reg   <= 1'b0;
            zero_reg  <= 1'b0;
            halt_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            pc_reg    <= pc_next;
            ir_reg    <= ir_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            alu_reg   <= alu_next;
            mdr_reg   <= mdr_next;
            jt_reg    <= jt_next;
            ovf_reg   <= ovf_next;
            zero_reg  <= zero_next;
            halt_reg  <= halt_next;
        end
    end

    assign fwd = '{phase: phase_next, pc: pc_next, alu: alu_next, ir: ir_next};

    always_comb begin
        res.phase           = phase_next;
        res.program_counter = pc_next;
        res.alu_value       = $signed(alu_next);
        res.overflow_flag   = ovf_next;
        res.zero_flag       = zero_next;
        res.halted          = halt_next;
        unique case (req.func)
            FN_RDREG: res.read_value = $signed(rf_a_q);
            FN_RDMEM: res.read_value = $signed(mem_q);
            default:  res.read_value = '0;
        endcase
    end

endmodule

### design/mcc_checker.sv
`include "multicycle_cpu_16bit_core_assert.svh"

module mcc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input mcc_pkg::mcc_res_t  m_res
);
    import mcc_pkg::*;

    // a stalled result stays put
    `MCC_ASSERT_NXT(a_res_hold, m_valid && !m_ready, m_valid && $stable(m_res))

    // the core only stalls requests when the result side is blocked
    `MCC_ASSERT_IMP(a_no_idle_stall, !s_ready, m_valid && !m_ready)

    // a halted core sits in fetch
    `MCC_ASSERT_IMP(a_halt_in_fetch, m_valid && m_res.halted,
                    m_res.phase == PH_FETCH)

    // decode follows a good fetch: PC at most one past the program area
    `MCC_ASSERT_IMP(a_decode_pc, m_valid && m_res.phase == PH_DECODE,
                    !m_res.halted && 9'(m_res.program_counter) <= 9'(PROGRAM_WORDS))

endmodule

bind multicycle_cpu_16bit_core mcc_checker u_mcc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_res   (m_res)
);

### dv/multicycle_cpu_16bit_core_tb.sv
module multicycle_cpu_16bit_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mcc_pkg::*;

    // ------------------------------------------------------------------
    // clock, reset, DUT ports
    // ------------------------------------------------------------------
    logic      aclk;
    logic      aresetn;
    logic      s_valid = 1'b0;
    logic      s_ready;
    mcc_req_t  s_req   = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    mcc_res_t  m_res;

    multicycle_cpu_16bit_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // sync reset, released once and never asserted again
    initial begin
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // hard stop in case a handshake hangs
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // shadow copy of the core state
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] mem_img  [MEM_WORDS];
    logic [DATA_W-1:0] regs_img [REG_COUNT];
    logic [PC_W-1:0]   pc_img;
    logic [PC_W-1:0]   jtgt_img;
    logic [DATA_W-1:0] ir_img;
    logic [DATA_W-1:0] opa_img;
    logic [DATA_W-1:0] opb_img;
    logic [DATA_W-1:0] alu_img;
    logic [DATA_W-1:0] mdr_img;
    logic [3:0]        phase_img;
    logic              ovf_img;
    logic              zf_img;
    logic              halt_img;

    // request backlog and the results the core owes us
    mcc_req_t requests_todo [$];
    mcc_res_t results_due   [$];

    int n_queued   = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_steps    = 0;
    int n_loads    = 0;
    int n_reads    = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    // handshake snapshots taken mid-cycle, used at the next rising edge
    bit       s_hs = 1'b0;
    bit       m_hs = 1'b0;
    mcc_res_t res_snap;
    mcc_res_t step_out;
    mcc_res_t due;

    // ALU: add sets overflow, sub sets overflow and zero, others leave flags
    task automatic alu_apply(input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y,
                             input logic [2:0] op);
        logic [DATA_W-1:0] r;
        case (op)
            ALU_ADD: begin
                r       = x + y;
                ovf_img = ~(x[15] ^ y[15]) & (x[15] ^ r[15]);
            end
            ALU_SUB: begin
                r       = x - y;
                ovf_img = (x[15] ^ y[15]) & (x[15] ^ r[15]);
                zf_img  = (r == '0);
            end
            ALU_AND: r = x & y;
            ALU_OR:  r = x | y;
            default: r = '0;
        endcase
        alu_img = r;
    endtask

    // one control phase of the core
    task automatic core_advance();
        logic [3:0]        op;
        logic [2:0]        rs;
        logic [2:0]        rt;
        logic [2:0]        rd;
        logic [2:0]        fn;
        logic [DATA_W-1:0] imm;
        logic [DATA_W-1:0] w;
        logic [3:0]        nxt;
        op  = ir_img[15:12];
        rs  = ir_img[11:9];
        rt  = ir_img[8:6];
        rd  = ir_img[5:3];
        fn  = ir_img[2:0];
        imm = {{10{ir_img[5]}}, ir_img[5:0]};
        nxt = PH_FETCH;
        case (phase_img)
            PH_FETCH: begin
                w = mem_img[pc_img];
                if (pc_img > PC_LAST || w == '0) begin
                    halt_img = 1'b1;
                end else begin
                    halt_img = 1'b0;
                    ir_img   = w;
                    alu_apply({8'h00, pc_img}, 16'd1, ALU_ADD);
                    pc_img   = alu_img[PC_W-1:0];
                    nxt      = PH_DECODE;
                end
            end
            PH_DECODE: begin
                opa_img  = regs_img[rs];
                opb_img  = regs_img[rt];
                alu_apply({8'h00, pc_img}, imm, ALU_ADD);
                jtgt_img = ir_img[7:0];
                if (op == OP_LW || op == OP_SW || op == OP_ADDI) nxt = PH_EXEC;
                else if (op == OP_RTYPE) nxt = PH_R_EXEC;
                else if (op == OP_BEQ)   nxt = PH_BEQ;
                else if (op == OP_JUMP)  nxt = PH_JUMP;
            end
            PH_EXEC: begin
                if (op == OP_LW || op == OP_SW || op == OP_ADDI) alu_apply(opa_img, imm, ALU_ADD);
                if (op == OP_LW)        nxt = PH_MEM;
                else if (op == OP_SW)   nxt = PH_SW;
                else if (op == OP_ADDI) nxt = PH_ADDI_WB;
            end
            PH_MEM: begin
                mdr_img = mem_img[alu_img[MEM_AW-1:0]];
                nxt     = PH_LW_WB;
            end
            PH_LW_WB:   regs_img[rt] = mdr_img;
            PH_ADDI_WB: regs_img[rt] = alu_img;
            PH_R_EXEC: begin
                alu_apply(opa_img, opb_img, fn);
                nxt = PH_R_WB;
            end
            PH_R_WB:    regs_img[rd] = alu_img;
            PH_JUMP:    pc_img = jtgt_img;
            default: ;  // sw, beq and undefined phases fall back to fetch
        endcase
        phase_img = nxt;
    endtask

    // apply one request to the shadow state, return the result it causes
    task automatic run_request(input mcc_req_t rq, output mcc_res_t rs);
        logic [DATA_W-1:0] rv;
        rv = '0;
        case (rq.func)
            FN_LOAD:  mem_img[rq.address] = rq.word;
            FN_STEP:  core_advance();
            FN_RDREG: rv = regs_img[rq.address[RF_AW-1:0]];
            default:  rv = mem_img[rq.address];
        endcase
        rs.phase           = phase_img;
        rs.program_counter = pc_img;
        rs.alu_value       = alu_img;
        rs.overflow_flag   = ovf_img;
        rs.zero_flag       = zf_img;
        rs.halted          = halt_img;
        rs.read_value      = rv;
    endtask

    // ------------------------------------------------------------------
    // mid-cycle sampling: values here hold through the next rising edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        s_hs     = aresetn && s_valid && s_ready;
        m_hs     = aresetn && m_valid && m_ready;
        res_snap = m_res;
    end

    // ------------------------------------------------------------------
    // driver: predicts at acceptance, then offers the next request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_req   <= '0;
        end else begin
            if (s_hs) begin
                run_request(s_req, step_out);
                results_due.push_back(step_out);
                n_accepted++;
                if (s_req.func == FN_STEP)      n_steps++;
                else if (s_req.func == FN_LOAD) n_loads++;
                else                            n_reads++;
            end
            if (!s_valid || s_hs) begin
                // no idling inside the calm window
                if (requests_todo.size() != 0 &&
                    ((n_accepted >= 900 && n_accepted < 1250) ||
                     $urandom_range(99) >= 16)) begin
                    s_valid <= 1'b1;
                    s_req   <= requests_todo.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, once, while requests keep coming
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_accepted >= 500) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // monitor: in-order compare against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_hs) begin
                if (results_due.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: unexpected result phase %0d pc %0h read %h",
                                 res_snap.phase, res_snap.program_counter,
                                 res_snap.read_value);
                end else begin
                    due = results_due.pop_front();
                    n_checked++;
                    if (res_snap.phase !== due.phase ||
                        res_snap.program_counter !== due.program_counter ||
                        res_snap.alu_value !== due.alu_value ||
                        res_snap.overflow_flag !== due.overflow_flag ||
                        res_snap.zero_flag !== due.zero_flag ||
                        res_snap.halted !== due.halted ||
                        res_snap.read_value !== due.read_value) begin
                        n_errors++;
                        if (n_errors <= 10) begin
                            $display("ERROR: result %0d exp/got: phase %0d/%0d pc %h/%h alu %h/%h",
                                     n_checked, due.phase, res_snap.phase,
                                     due.program_counter, res_snap.program_counter,
                                     due.alu_value, res_snap.alu_value);
                            $display("  ovf %b/%b zero %b/%b halt %b/%b read %h/%h",
                                     due.overflow_flag, res_snap.overflow_flag,
                                     due.zero_flag, res_snap.zero_flag,
                                     due.halted, res_snap.halted,
                                     due.read_value, res_snap.read_value);
                        end
                    end
                end
            end
            m_ready <= (hold_left == 0) &&
                       ((n_checked >= 900 && n_checked < 1250) ||
                        $urandom_range(99) >= 16);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send(input logic [1:0] fn, input logic [MEM_AW-1:0] addr,
                        input logic [DATA_W-1:0] w);
        mcc_req_t rq;
        rq.func    = fn;
        rq.address = addr;
        rq.word    = w;
        requests_todo.push_back(rq);
        n_queued++;
    endtask

    // wait until the shadow state reflects every queued request
    task automatic settle();
        while (n_accepted != n_queued) @(negedge aclk);
    endtask

    // a run of phase steps with some reads mixed in
    task automatic send_steps(input int n);
        int sel;
        repeat (n) begin
            sel = $urandom_range(99);
            if (sel < 84)      send(FN_STEP, 8'($urandom), 16'($urandom));
            else if (sel < 92) send(FN_RDREG, 8'($urandom), 16'($urandom));
            else               send(FN_RDMEM, 8'($urandom), 16'($urandom));
        end
    endtask

    // mostly well-formed instructions, some unfinished/unknown/zero words
    function automatic logic [DATA_W-1:0] rand_instr();
        int                pick;
        logic [3:0]        op;
        logic [DATA_W-1:0] w;
        pick = $urandom_range(99);
        w    = 16'($urandom);
        if (pick < 35) begin
            w[15:12] = OP_RTYPE;
            if ($urandom_range(99) < 80) begin
                case ($urandom_range(3))
                    0:       w[2:0] = ALU_ADD;
                    1:       w[2:0] = ALU_SUB;
                    2:       w[2:0] = ALU_AND;
                    default: w[2:0] = ALU_OR;
                endcase
            end
        end else if (pick < 50) begin
            w[15:12] = OP_ADDI;
        end else if (pick < 65) begin
            w[15:12] = OP_LW;
        end else if (pick < 75) begin
            w[15:12] = OP_JUMP;
        end else if (pick < 82) begin
            w[15:12] = OP_SW;
        end else if (pick < 88) begin
            w[15:12] = OP_BEQ;
        end else if (pick < 94) begin
            do op = 4'($urandom_range(15));
            while (op == OP_RTYPE || op == OP_JUMP || op == OP_ADDI ||
                   op == OP_BEQ || op == OP_LW || op == OP_SW);
            w[15:12] = op;
        end else begin
            w = '0;
        end
        return w;
    endfunction

    // keep the PC inside the program area: jumps stay low, and the last
    // program word can only be a jump or a halting zero
    function automatic logic [DATA_W-1:0] safe_word(input logic [MEM_AW-1:0] addr,
                                                    input logic [DATA_W-1:0] w);
        logic [DATA_W-1:0] r;
        r = w;
        if (addr <= PC_LAST) begin
            if (r[15:12] == OP_JUMP) begin
                r[7] = 1'b0;
            end else if (addr == PC_LAST && r != '0) begin
                r[15:12] = OP_JUMP;
                r[7]     = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] rand_data();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            3:       return 16'h0001;
            4:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        int                k;
        int                n;
        int                pick;
        logic [1:0]        fn;
        logic [MEM_AW-1:0] a;
        logic [DATA_W-1:0] w;

        foreach (mem_img[i]) mem_img[i] = '0;
        foreach (regs_img[i]) regs_img[i] = '0;
        pc_img    = '0;
        jtgt_img  = '0;
        ir_img    = '0;
        opa_img   = '0;
        opb_img   = '0;
        alu_img   = '0;
        mdr_img   = '0;
        phase_img = PH_FETCH;
        ovf_img   = 1'b0;
        zf_img    = 1'b0;
        halt_img  = 1'b0;

        // directed: step on empty memory halts on a zero word
        send(FN_STEP, 8'h00, 16'h0000);
        send(FN_RDMEM, 8'hFF, 16'hFFFF);
        send(FN_LOAD, 8'hFF, 16'hFFFF);
        // lw r1,-1(r0) ; sub r2,r1,r1 ; j 100 (zero word there)
        send(FN_LOAD, 8'h00, {OP_LW, 3'd0, 3'd1, 6'h3F});
        send(FN_LOAD, 8'h01, {OP_RTYPE, 3'd1, 3'd1, 3'd2, ALU_SUB});
        send(FN_LOAD, 8'h02, {OP_JUMP, 4'h0, 8'd100});
        repeat (13) send(FN_STEP, 8'hFF, 16'h0000);
        send(FN_RDREG, 8'hF9, 16'h0000);
        send(FN_RDREG, 8'h02, 16'hFFFF);
        send(FN_RDMEM, 8'h00, 16'h0000);

        // random: mostly short programs at the fetch address, then run them
        while (n_queued < 1950) begin
            settle();
            pick = halt_img ? 0 : $urandom_range(99);
            if (pick < 55) begin
                n = $urandom_range(3, 12);
                for (k = 0; k < n && pc_img + k <= PC_LAST; k++) begin
                    a = pc_img + 8'(k);
                    send(FN_LOAD, a, safe_word(a, rand_instr()));
                end
                repeat ($urandom_range(0, 3))
                    send(FN_LOAD, 8'($urandom_range(128, 255)), rand_data());
                send_steps($urandom_range(8, 40));
            end else if (pick < 70) begin
                send_steps($urandom_range(20, 60));
            end else if (pick < 85) begin
                // noise: anything, only program words kept safe
                repeat ($urandom_range(5, 20)) begin
                    fn = 2'($urandom);
                    a  = 8'($urandom);
                    w  = 16'($urandom);
                    if (fn == FN_LOAD) w = safe_word(a, w);
                    send(fn, a, w);
                end
            end else begin
                // data area traffic
                repeat ($urandom_range(4, 16)) begin
                    a = 8'($urandom_range(128, 255));
                    if ($urandom_range(1)) send(FN_LOAD, a, rand_data());
                    else                   send(FN_RDMEM, a, 16'($urandom));
                end
            end
        end

        // finish the current instruction, then jump past the program area
        settle();
        while (phase_img != PH_FETCH) begin
            send(FN_STEP, 8'h00, 16'h0000);
            settle();
        end
        send(FN_LOAD, pc_img, {OP_JUMP, 4'h0, 8'hC8});
        repeat (5) send(FN_STEP, 8'hFF, 16'hFFFF);
        send(FN_RDREG, 8'h07, 16'h0000);
        send(FN_RDMEM, 8'hC8, 16'h0000);

        settle();
        while (results_due.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("Run: %0d requests (%0d phase steps, %0d loads, %0d reads), %0d results checked",
                 n_accepted, n_steps, n_loads, n_reads, n_checked);
        $display("Run: %0d mismatches, final PC %h, one 300-cycle result stall applied",
                 n_errors, pc_img);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/mcc_pkg.sv
design/mcc_main_mem.sv
design/mcc_regfile.sv
design/mcc_alu.sv
design/mcc_exec.sv
design/multicycle_cpu_16bit_core.sv
design/mcc_checker.sv
dv/multicycle_cpu_16bit_core_tb.sv
